// ===== hdl/rational_arithmetic_unit_top_assert.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/rau_pkg.sv =====
// Shared codes and types for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam logic [2:0] CMD_NEG = 3'd5;
  localparam logic [2:0] CMD_INC = 3'd6;
  localparam logic [2:0] CMD_DEC = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_FORM,
    OP_GCD,
    OP_DIV_LD_A,
    OP_DIV_STEP,
    OP_DIV_LD_B,
    OP_EMIT_ERR,
    OP_EMIT_CMP,
    OP_EMIT_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       err;
    logic       u_zero;
    logic [2:0] cmd;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/rau_datapath.sv =====
// Datapath: operand registers, shared multiplier, gcd unit and restoring divider.
`default_nettype none
module rau_datapath #(
  parameter int W = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire rau_pkg::dp_cmd_t    dp_cmd_i,
  output rau_pkg::dp_status_t      dp_status_o,
  input  wire  [2:0]               cmd_i,
  input  wire  [W-1:0]             a_num_i,
  input  wire  [W-2:0]             a_den_i,
  input  wire  [W-1:0]             b_num_i,
  input  wire  [W-2:0]             b_den_i,
  output logic [2*W-1:0]           res_num_o,
  output logic [2*W-2:0]           res_den_o,
  output logic                     less_o,
  output logic                     equal_o,
  output logic                     greater_o,
  output logic                     error_o,
  output logic                     valid_o
);

  localparam int PW = 2 * W;
  localparam int KW = $clog2(PW);

  logic [2:0]          cmd_q;
  logic signed [W-1:0] an_q, bn_q;
  logic [W-2:0]        ad_q, bd_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic [PW-1:0]       u_q, v_q, mag_q, den_q, qa_q;
  logic [KW-1:0]       k_q;
  logic                neg_q;
  logic [PW-1:0]       rem_q, quo_q;
  logic [PW-1:0]       res_num_q;
  logic [PW-2:0]       res_den_q;
  logic                less_q, equal_q, greater_q, error_q, valid_q;

  logic signed [W:0]     mul_a, mul_b;
  logic signed [2*W+1:0] mul_p;
  logic signed [PW-1:0]  n_form, d_form, an_ext, ad_ext;
  logic [PW-1:0]         g;
  logic [PW:0]           rem_sh;
  logic                  fit;

  // Shared signed multiplier; denominators enter zero extended.
  always_comb begin
    mul_a = {an_q[W-1], an_q};
    mul_b = {2'b00, bd_q};
    case (dp_cmd_i.op)
      rau_pkg::OP_MUL1: begin
        mul_a = {bn_q[W-1], bn_q};
        mul_b = {2'b00, ad_q};
      end
      rau_pkg::OP_MUL2: begin
        mul_a = {2'b00, ad_q};
        mul_b = {2'b00, bd_q};
      end
      rau_pkg::OP_MUL3: begin
        mul_a = {an_q[W-1], an_q};
        mul_b = {bn_q[W-1], bn_q};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    an_ext = PW'(an_q);
    ad_ext = PW'({1'b0, ad_q});
    n_form = p0_q + p1_q;
    d_form = p2_q;
    case (cmd_q)
      rau_pkg::CMD_SUB: n_form = p0_q - p1_q;
      rau_pkg::CMD_MUL: n_form = p3_q;
      rau_pkg::CMD_DIV: begin
        n_form = p1_q[PW-1] ? -p0_q : p0_q;
        d_form = p1_q[PW-1] ? -p1_q : p1_q;
      end
      rau_pkg::CMD_NEG: begin
        n_form = -an_ext;
        d_form = ad_ext;
      end
      rau_pkg::CMD_INC: begin
        n_form = an_ext + ad_ext;
        d_form = ad_ext;
      end
      rau_pkg::CMD_DEC: begin
        n_form = an_ext - ad_ext;
        d_form = ad_ext;
      end
      default: ;
    endcase
  end

  assign g      = v_q << k_q;
  assign rem_sh = {rem_q, quo_q[PW-1]};
  assign fit    = rem_sh >= {1'b0, g};

  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      rau_pkg::OP_LOAD: begin
        cmd_q <= cmd_i;
        an_q  <= a_num_i;
        ad_q  <= a_den_i;
        bn_q  <= b_num_i;
        bd_q  <= b_den_i;
      end
      rau_pkg::OP_MUL0: p0_q <= mul_p[PW-1:0];
      rau_pkg::OP_MUL1: p1_q <= mul_p[PW-1:0];
      rau_pkg::OP_MUL2: p2_q <= mul_p[PW-1:0];
      rau_pkg::OP_MUL3: p3_q <= mul_p[PW-1:0];
      rau_pkg::OP_FORM: begin
        neg_q <= n_form[PW-1];
        mag_q <= n_form[PW-1] ? -n_form : n_form;
        u_q   <= n_form[PW-1] ? -n_form : n_form;
        den_q <= d_form;
        v_q   <= d_form;
        k_q   <= '0;
      end
      rau_pkg::OP_GCD: begin
        // Binary gcd: strip common twos, then subtract the smaller odd value.
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      rau_pkg::OP_DIV_LD_A: begin
        rem_q <= '0;
        quo_q <= mag_q;
      end
      rau_pkg::OP_DIV_STEP: begin
        rem_q <= fit ? PW'(rem_sh - {1'b0, g}) : rem_sh[PW-1:0];
        quo_q <= {quo_q[PW-2:0], fit};
      end
      rau_pkg::OP_DIV_LD_B: begin
        qa_q  <= quo_q;
        rem_q <= '0;
        quo_q <= den_q;
      end
      default: ;
    endcase
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      rau_pkg::OP_EMIT_ERR, rau_pkg::OP_EMIT_CMP: begin
        res_num_q <= '0;
        res_den_q <= '0;
        less_q    <= (dp_cmd_i.op == rau_pkg::OP_EMIT_CMP) && (p0_q < p1_q);
        equal_q   <= (dp_cmd_i.op == rau_pkg::OP_EMIT_CMP) && (p0_q == p1_q);
        greater_q <= (dp_cmd_i.op == rau_pkg::OP_EMIT_CMP) && (p0_q > p1_q);
        error_q   <= dp_cmd_i.op == rau_pkg::OP_EMIT_ERR;
      end
      rau_pkg::OP_EMIT_RES: begin
        res_num_q <= neg_q ? -qa_q : qa_q;
        res_den_q <= quo_q[PW-2:0];
        less_q    <= 1'b0;
        equal_q   <= 1'b0;
        greater_q <= 1'b0;
        error_q   <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (dp_cmd_i.op == rau_pkg::OP_EMIT_ERR) ||
                 (dp_cmd_i.op == rau_pkg::OP_EMIT_CMP) ||
                 (dp_cmd_i.op == rau_pkg::OP_EMIT_RES);
    end
  end

  assign dp_status_o.err    = (ad_q == '0) ||
                              ((cmd_q <= rau_pkg::CMD_CMP) && (bd_q == '0)) ||
                              ((cmd_q == rau_pkg::CMD_DIV) && (bn_q == '0));
  assign dp_status_o.u_zero = u_q == '0;
  assign dp_status_o.cmd    = cmd_q;

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign less_o    = less_q;
  assign equal_o   = equal_q;
  assign greater_o = greater_q;
  assign error_o   = error_q;
  assign valid_o   = valid_q;

endmodule
`default_nettype wire

// ===== hdl/rau_ctrl.sv =====
// Controller: sequences multiply, gcd and divide steps for one command.
`default_nettype none
`include "rational_arithmetic_unit_top_assert.svh"
module rau_ctrl #(
  parameter int W = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  output logic                     busy_o,
  output rau_pkg::dp_cmd_t         dp_cmd_o,
  input  wire rau_pkg::dp_status_t dp_status_i
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_MUL3  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_FORM  = 4'd7;
  localparam logic [3:0] S_GCD   = 4'd8;
  localparam logic [3:0] S_DIV_A = 4'd9;
  localparam logic [3:0] S_LD_B  = 4'd10;
  localparam logic [3:0] S_DIV_B = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last;

  assign last = cnt_q == CW'(PW - 1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dp_cmd_o.op = rau_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dp_cmd_o.op = rau_pkg::OP_LOAD;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dp_status_i.err) begin
          dp_cmd_o.op = rau_pkg::OP_EMIT_ERR;
          state_d     = S_IDLE;
        end else if (dp_status_i.cmd > rau_pkg::CMD_CMP) begin
          state_d = S_FORM;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        dp_cmd_o.op = rau_pkg::OP_MUL0;
        state_d     = S_MUL1;
      end
      S_MUL1: begin
        dp_cmd_o.op = rau_pkg::OP_MUL1;
        state_d     = (dp_status_i.cmd == rau_pkg::CMD_CMP) ? S_CMP : S_MUL2;
      end
      S_MUL2: begin
        dp_cmd_o.op = rau_pkg::OP_MUL2;
        state_d     = S_MUL3;
      end
      S_MUL3: begin
        dp_cmd_o.op = rau_pkg::OP_MUL3;
        state_d     = S_FORM;
      end
      S_CMP: begin
        dp_cmd_o.op = rau_pkg::OP_EMIT_CMP;
        state_d     = S_IDLE;
      end
      S_FORM: begin
        dp_cmd_o.op = rau_pkg::OP_FORM;
        state_d     = S_GCD;
      end
      S_GCD: begin
        if (dp_status_i.u_zero) begin
          dp_cmd_o.op = rau_pkg::OP_DIV_LD_A;
          cnt_d       = '0;
          state_d     = S_DIV_A;
        end else begin
          dp_cmd_o.op = rau_pkg::OP_GCD;
        end
      end
      S_DIV_A: begin
        dp_cmd_o.op = rau_pkg::OP_DIV_STEP;
        cnt_d       = cnt_q + 1'b1;
        if (last) state_d = S_LD_B;
      end
      S_LD_B: begin
        dp_cmd_o.op = rau_pkg::OP_DIV_LD_B;
        cnt_d       = '0;
        state_d     = S_DIV_B;
      end
      S_DIV_B: begin
        dp_cmd_o.op = rau_pkg::OP_DIV_STEP;
        cnt_d       = cnt_q + 1'b1;
        if (last) state_d = S_EMIT;
      end
      S_EMIT: begin
        dp_cmd_o.op = rau_pkg::OP_EMIT_RES;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

  `RAU_ASSERT_NEXT(a_start_check, clk_i, rst_ni, start_i && !busy_o, state_q == S_CHECK)
  `RAU_ASSERT_NEXT(a_gcd_to_div, clk_i, rst_ni, state_q == S_GCD && dp_status_i.u_zero,
                   state_q == S_DIV_A && cnt_q == '0)
  `RAU_ASSERT_NEXT(a_div_a_done, clk_i, rst_ni, state_q == S_DIV_A && last, state_q == S_LD_B)
  `RAU_ASSERT_IMP(a_idle_no_op, clk_i, rst_ni, state_q == S_IDLE && !start_i,
                  dp_cmd_o.op == rau_pkg::OP_NONE)

endmodule
`default_nettype wire

// ===== hdl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit.
// Usage: drive cmd_i and the two fractions a_num_i/a_den_i and b_num_i/b_den_i,
// raise start; the command transfers at a clock edge with start high and
// busy low. busy stays high until the result is produced, one command at a time.
// The result appears for one cycle with valid_o high: res_num_o/res_den_o hold
// the reduced fraction (denominator positive, zero shown as 0/1), less_o,
// equal_o and greater_o answer a compare, error_o flags a zero denominator or
// a division by zero. The receiver cannot stall; every result transfers.
// Sequence: an error result is emitted from the check state; a compare forms
// two cross products and emits. Other commands run the multiplies (skipped by
// negate, increment and decrement), then a binary gcd of the numerator
// magnitude and the denominator, then two restoring divides by the gcd, one
// for the numerator and one for the denominator, bit by bit, and emit. One
// shared multiplier forms the products one at a time; a compare uses two of
// them. Reset returns the controller to idle and clears valid_o.
`default_nettype none
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire  [2:0]                    cmd_i,
  input  wire  [OPERAND_WIDTH-1:0]      a_num_i,
  input  wire  [OPERAND_WIDTH-2:0]      a_den_i,
  input  wire  [OPERAND_WIDTH-1:0]      b_num_i,
  input  wire  [OPERAND_WIDTH-2:0]      b_den_i,
  output logic                          valid_o,
  output logic [2*OPERAND_WIDTH-1:0]    res_num_o,
  output logic [2*OPERAND_WIDTH-2:0]    res_den_o,
  output logic                          less_o,
  output logic                          equal_o,
  output logic                          greater_o,
  output logic                          error_o
);

  rau_pkg::dp_cmd_t    dp_cmd;
  rau_pkg::dp_status_t dp_status;

  rau_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  rau_datapath #(.W(OPERAND_WIDTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status),
    .cmd_i       (cmd_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .less_o      (less_o),
    .equal_o     (equal_o),
    .greater_o   (greater_o),
    .error_o     (error_o),
    .valid_o     (valid_o)
  );

endmodule
`default_nettype wire
